FILE: sv/mctb_pkg.sv
// mctb_pkg: shared types and codes for the multi-channel timer bank.
// Holds the command/result item structs and the operation codes.
// No dependencies.
`timescale 1ns / 1ps

package mctb_pkg;

    // Operation codes carried in the command item
    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_CONFIGURE    = 3'd1,
        OP_REMOVE       = 3'd2,
        OP_START        = 3'd3,
        OP_STOP         = 3'd4,
        OP_RESTART      = 3'd5,
        OP_SET_INTERVAL = 3'd6,
        OP_SERVICE_ACK  = 3'd7
    } op_t;

    // Mode bit positions inside a channel's mode field
    localparam int MODE_PERIODIC  = 0;
    localparam int MODE_INTERRUPT = 1;
    localparam int MODE_PRECISE   = 2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  channel;
        logic [31:0] interval;
        logic        periodic;
        logic        interrupt_mode;
        logic        precise;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  expired_mask;
        logic [7:0]  callback_mask;
        logic [7:0]  done_mask;
        logic [7:0]  running_mask;
        logic [63:0] tick_count;
    } result_t;

endpackage

FILE: sv/multi_channel_timer_bank.sv
// multi_channel_timer_bank: bank of countdown timer channels driven by one tick.
// Depends on mctb_pkg for the item structs and operation codes.
//
// Usage:
//   An item (tick or channel command) is presented on command and taken at a
//   rising edge with start high and busy low. busy stays low: the bank takes
//   one item every cycle.
//   Each item yields exactly one result item on result, flagged by done for a
//   single cycle. The item passes through the command register, then the
//   per-channel update into the result register. All channels update in
//   parallel in that step, so the count/reload decrement-and-compare of one
//   channel sets the cycle time.
//   The receiver cannot stall; results must be taken in the cycle they appear.
//   Reset (rst_n low) clears all channels, the tick counter, and any item in
//   flight. Commands to a channel at or above CHANNELS do nothing; channels
//   above seven cannot be addressed and do not show in the 8-bit masks.
`timescale 1ns / 1ps

module multi_channel_timer_bank
    import mctb_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    command,
    output logic    done,
    output result_t result
);

    localparam int MASK_W = (CHANNELS > 8) ? CHANNELS : 8;

    // Command register
    cmd_t cmd_reg;
    logic cmd_valid_reg;

    // Channel state
    logic [CHANNELS-1:0] alloc_reg,  alloc_next;
    logic [CHANNELS-1:0] active_reg, active_next;
    logic [CHANNELS-1:0] expd_reg,   expd_next;
    logic [31:0]         count_reg  [CHANNELS], count_next  [CHANNELS];
    logic [31:0]         reload_reg [CHANNELS], reload_next [CHANNELS];
    logic [2:0]          mode_reg   [CHANNELS], mode_next   [CHANNELS];
    logic [63:0]         ticks_reg, ticks_next;

    // Result register
    result_t result_reg, result_next;
    logic    done_reg;

    logic [CHANNELS-1:0] expired_vec, callback_vec;
    logic [MASK_W-1:0]   expired_ext, callback_ext, done_ext, running_ext;
    logic                is_tick;

    assign busy = 1'b0;

    // Input register: one item per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= command;
        end
    end

    assign is_tick = cmd_valid_reg && (cmd_reg.operation == OP_TICK);

    // Per-channel update
    always_comb
    begin
        logic [31:0] dec;
        logic        sel;
        ticks_next   = is_tick ? ticks_reg + 64'd1 : ticks_reg;
        alloc_next   = alloc_reg;
        active_next  = active_reg;
        expd_next    = expd_reg;
        expired_vec  = '0;
        callback_vec = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            count_next[i]  = count_reg[i];
            reload_next[i] = reload_reg[i];
            mode_next[i]   = mode_reg[i];
            dec            = count_reg[i] - 32'd1;
            sel            = cmd_valid_reg && (int'(cmd_reg.channel) == i);

            if (is_tick)
            begin
                if (alloc_reg[i] && active_reg[i])
                begin
                    count_next[i] = dec;
                    if (dec == 32'd0)
                    begin
                        expd_next[i]   = 1'b1;
                        expired_vec[i] = 1'b1;
                        if (mode_reg[i][MODE_INTERRUPT])
                        begin
                            if (mode_reg[i][MODE_PERIODIC])
                                count_next[i] = reload_reg[i];
                            else
                                active_next[i] = 1'b0;
                            callback_vec[i] = 1'b1;
                        end
                        else if (mode_reg[i][MODE_PERIODIC])
                        begin
                            count_next[i] = reload_reg[i];
                            if (!mode_reg[i][MODE_PRECISE])
                                active_next[i] = 1'b0;
                        end
                        else
                        begin
                            active_next[i] = 1'b0;
                        end
                    end
                end
            end
            else if (sel && cmd_reg.operation == OP_CONFIGURE)
            begin
                alloc_next[i]  = 1'b1;
                active_next[i] = 1'b0;
                expd_next[i]   = 1'b0;
                reload_next[i] = cmd_reg.interval;
                count_next[i]  = cmd_reg.interval;
                mode_next[i]   = {cmd_reg.precise, cmd_reg.interrupt_mode,
                                  cmd_reg.periodic};
            end
            else if (sel && alloc_reg[i])
            begin
                case (cmd_reg.operation)
                    OP_REMOVE:
                    begin
                        alloc_next[i]  = 1'b0;
                        active_next[i] = 1'b0;
                        expd_next[i]   = 1'b0;
                    end
                    OP_START:
                    begin
                        if (count_reg[i] == 32'd0)
                            count_next[i] = reload_reg[i];
                        active_next[i] = 1'b1;
                        expd_next[i]   = 1'b0;
                    end
                    OP_STOP:
                    begin
                        active_next[i] = 1'b0;
                        expd_next[i]   = 1'b0;
                    end
                    OP_RESTART:
                    begin
                        count_next[i]  = reload_reg[i];
                        active_next[i] = 1'b1;
                        expd_next[i]   = 1'b0;
                    end
                    OP_SET_INTERVAL:
                    begin
                        reload_next[i] = cmd_reg.interval;
                    end
                    OP_SERVICE_ACK:
                    begin
                        // main-loop handling of a service-mode expiry
                        if (!mode_reg[i][MODE_INTERRUPT] && expd_reg[i])
                        begin
                            expd_next[i]    = 1'b0;
                            callback_vec[i] = 1'b1;
                            if (!mode_reg[i][MODE_PERIODIC])
                                active_next[i] = 1'b0;
                            else if (!mode_reg[i][MODE_PRECISE])
                                active_next[i] = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result assembly: only channels 0..7 show in the masks
    always_comb
    begin
        expired_ext  = MASK_W'(expired_vec);
        callback_ext = MASK_W'(callback_vec);
        done_ext     = MASK_W'(expd_next);
        running_ext  = MASK_W'(active_next);
        result_next.expired_mask  = expired_ext[7:0];
        result_next.callback_mask = callback_ext[7:0];
        result_next.done_mask     = done_ext[7:0];
        result_next.running_mask  = running_ext[7:0];
        result_next.tick_count    = ticks_next;
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg  <= '0;
            active_reg <= '0;
            expd_reg   <= '0;
            ticks_reg  <= '0;
            done_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                count_reg[i]  <= '0;
                reload_reg[i] <= '0;
                mode_reg[i]   <= '0;
            end
        end
        else
        begin
            alloc_reg  <= alloc_next;
            active_reg <= active_next;
            expd_reg   <= expd_next;
            ticks_reg  <= ticks_next;
            done_reg   <= cmd_valid_reg;
            for (int i = 0; i < CHANNELS; i++)
            begin
                count_reg[i]  <= count_next[i];
                reload_reg[i] <= reload_next[i];
                mode_reg[i]   <= mode_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("accepted item did not produce a result two cycles later");

    a_flags_need_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        ((expd_reg | active_reg) & ~alloc_reg) == '0)
        else $error("done or running flag set on an unallocated channel");

    a_ticks_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (ticks_reg != $past(ticks_reg)) |->
            ($past(is_tick) && ticks_reg == $past(ticks_reg) + 64'd1))
        else $error("tick counter moved without a tick item");

endmodule
